@@ hdl/mbe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_pkg
// shared types, constants and helpers of the escape-time engine
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int PIX_W   = 10;
  localparam int CNT_W   = 16;
  localparam int COORD_W = 32;
  localparam int STEP_W  = 31;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 2;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [IDX_W-1:0] REG_STEP     = 2'd2;
  localparam logic [IDX_W-1:0] REG_MAX_ITER = 2'd3;

  localparam logic signed [COORD_W-1:0] ORIGIN_RST   = -32'sd536870912;
  localparam logic        [STEP_W-1:0]  STEP_RST     = 31'd1048576;
  localparam logic        [CNT_W-1:0]   MAX_ITER_RST = 16'd50;

  // decoupling queue between front and engine
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic        [STEP_W-1:0]  pixel_step;
    logic        [CNT_W-1:0]   max_iterations;
  } cfg_t;

  typedef struct packed {
    logic        [PIX_W-1:0]   px;
    logic        [PIX_W-1:0]   py;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } point_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
  } queue_status_t;

  typedef struct packed {
    logic busy;
  } core_status_t;

  localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_LO = -64'sh0000_0000_8000_0000;

  // clamp to the signed 32-bit range
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/mbe_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbe channel interfaces
// pixel request channel and result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface mbe_pix_if;
  logic                     valid;
  logic                     ready;
  logic [mbe_pkg::PIX_W-1:0] pixel_x;
  logic [mbe_pkg::PIX_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mbe_res_if;
  logic                     valid;
  logic                     ready;
  logic [mbe_pkg::PIX_W-1:0] out_x;
  logic [mbe_pkg::PIX_W-1:0] out_y;
  logic [mbe_pkg::CNT_W-1:0] iteration_count;

  modport source (output valid, output out_x, output out_y, output iteration_count,
                  input ready);
  modport sink   (input valid, input out_x, input out_y, input iteration_count,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/mbe_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_front
// accepts pixel requests and maps them to the complex point c
// ----------------------------------------------------------------------------
module mbe_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mbe_pkg::cfg_t   cfg_i,
  mbe_pix_if.sink              pix_i,
  output logic                 push_valid_o,
  input  wire logic            push_ready_i,
  output mbe_pkg::point_t      push_data_o
);

  logic            stage_valid_q;
  mbe_pkg::point_t stage_q;
  mbe_pkg::point_t stage_d;

  logic        [40:0] prod_x;
  logic        [40:0] prod_y;
  logic signed [42:0] sum_x;
  logic signed [42:0] sum_y;

  always_comb begin
    prod_x = pix_i.pixel_x * cfg_i.pixel_step;
    prod_y = pix_i.pixel_y * cfg_i.pixel_step;
    sum_x  = 43'(cfg_i.origin_x) + {2'b00, prod_x};
    sum_y  = 43'(cfg_i.origin_y) + {2'b00, prod_y};
    stage_d.px = pix_i.pixel_x;
    stage_d.py = pix_i.pixel_y;
    stage_d.cx = mbe_pkg::sat32(64'(sum_x));
    stage_d.cy = mbe_pkg::sat32(64'(sum_y));
  end

  assign pix_i.ready  = !stage_valid_q || push_ready_i;
  assign push_valid_o = stage_valid_q;
  assign push_data_o  = stage_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (pix_i.ready) begin
      stage_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_i.valid && pix_i.ready) begin
      stage_q <= stage_d;
    end
  end

endmodule
`default_nettype wire

@@ hdl/mbe_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_queue
// short fifo of mapped points between front and engine
// ----------------------------------------------------------------------------
module mbe_queue (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_valid_i,
  output logic                        push_ready_o,
  input  wire mbe_pkg::point_t        push_data_i,
  output logic                        pop_valid_o,
  input  wire logic                   pop_ready_i,
  output mbe_pkg::point_t             pop_data_o,
  output mbe_pkg::queue_status_t      status_o
);

  mbe_pkg::point_t                     mem_q [mbe_pkg::QUEUE_DEPTH];
  logic [mbe_pkg::QPTR_W-1:0]          wr_ptr_q;
  logic [mbe_pkg::QPTR_W-1:0]          rd_ptr_q;
  logic [mbe_pkg::QCNT_W-1:0]          count_q;
  logic                                do_push;
  logic                                do_pop;

  localparam logic [mbe_pkg::QCNT_W-1:0] DEPTH_C = mbe_pkg::QCNT_W'(mbe_pkg::QUEUE_DEPTH);
  localparam logic [mbe_pkg::QPTR_W-1:0] LAST_C  =
    mbe_pkg::QPTR_W'(mbe_pkg::QUEUE_DEPTH - 1);

  assign push_ready_o    = count_q != DEPTH_C;
  assign pop_valid_o     = count_q != '0;
  assign pop_data_o      = mem_q[rd_ptr_q];
  assign do_push         = push_valid_i && push_ready_o;
  assign do_pop          = pop_valid_o && pop_ready_i;
  assign status_o.count  = count_q;
  assign status_o.full   = !push_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

@@ hdl/mbe_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbe_core
// iterates z = z*z + c for one point at a time and holds the result
// ----------------------------------------------------------------------------
module mbe_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mbe_pkg::cfg_t         cfg_i,
  input  wire logic                  pop_valid_i,
  output logic                       pop_ready_o,
  input  wire mbe_pkg::point_t       pop_data_i,
  mbe_res_if.source                  res_o,
  output mbe_pkg::core_status_t      status_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;

  localparam logic signed [36:0] MAG_LIMIT = 37'sd1073741824;  // 4.0 in Q4.28

  logic [1:0] state_q;
  logic [1:0] state_d;

  logic signed [mbe_pkg::COORD_W-1:0] zx_q, zy_q, cx_q, cy_q;
  logic        [mbe_pkg::PIX_W-1:0]   px_q, py_q;
  logic        [mbe_pkg::CNT_W-1:0]   count_q;
  logic signed [63:0]                 prod_xx_q, prod_yy_q, prod_xy_q;

  logic                               out_valid_q;
  logic        [mbe_pkg::PIX_W-1:0]   out_x_q, out_y_q;
  logic        [mbe_pkg::CNT_W-1:0]   out_cnt_q;

  logic signed [35:0] sq_x, sq_y;
  logic signed [36:0] cross_term, mag;
  logic signed [37:0] nx, ny;
  logic               done;
  logic               out_free;
  logic               load_out;
  logic               step;

  always_comb begin
    sq_x       = prod_xx_q[63:28];
    sq_y       = prod_yy_q[63:28];
    cross_term = prod_xy_q[63:27];
    mag        = 37'(sq_x) + 37'(sq_y);
    nx         = 38'(sq_x) - 38'(sq_y) + 38'(cx_q);
    ny         = 38'(cross_term) + 38'(cy_q);
    done       = (mag >= MAG_LIMIT) || (count_q >= cfg_i.max_iterations);
  end

  assign out_free    = !out_valid_q || res_o.ready;
  assign load_out    = (state_q == ST_EVAL) && done && out_free;
  assign step        = (state_q == ST_EVAL) && !done;
  assign pop_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (pop_valid_i) state_d = ST_MUL;
      ST_MUL:  state_d = ST_EVAL;
      ST_EVAL: begin
        if (step) begin
          state_d = ST_MUL;
        end else if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      zx_q    <= '0;
      zy_q    <= '0;
      count_q <= '0;
      cx_q    <= pop_data_i.cx;
      cy_q    <= pop_data_i.cy;
      px_q    <= pop_data_i.px;
      py_q    <= pop_data_i.py;
    end else if (step) begin
      zx_q    <= mbe_pkg::sat32(64'(nx));
      zy_q    <= mbe_pkg::sat32(64'(ny));
      count_q <= count_q + 1'b1;
    end
    if (state_q == ST_MUL) begin
      prod_xx_q <= zx_q * zx_q;
      prod_yy_q <= zy_q * zy_q;
      prod_xy_q <= zx_q * zy_q;
    end
    if (load_out) begin
      out_x_q   <= px_q;
      out_y_q   <= py_q;
      out_cnt_q <= count_q;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.out_x           = out_x_q;
  assign res_o.out_y           = out_y_q;
  assign res_o.iteration_count = out_cnt_q;
  assign status_o.busy         = (state_q != ST_IDLE);

endmodule
`default_nettype wire

@@ hdl/mandelbrot_escape_time.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// escape-time iteration count for one pixel of a mandelbrot view
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  pix_i     in    valid/ready      pixel_x[9:0], pixel_y[9:0]
//  res_o     out   valid/ready      out_x[9:0], out_y[9:0], iteration_count[15:0]
//  cfg       in    cfg_we_i         cfg_idx_i[1:0], cfg_wdata_i[31:0]
//
//  a pixel takes n iterations in the engine, n being the iterations done
//  (0..max_iterations); each iteration passes once through the shared
//  multiply / evaluate loop. the front maps a pixel into its registered stage.
//  reset is asynchronous, active low; the registers come back to a -2-2i
//  origin, a step of 4/1024 and a limit of 50.
//  a stalled result sits in the output register; the engine ends its pixel and
//  waits, the queue and front stage fill, then pix_i.ready drops.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [mbe_pkg::IDX_W-1:0]   cfg_idx_i,
  input  wire logic [mbe_pkg::CFG_W-1:0]   cfg_wdata_i,
  mbe_pix_if.sink                          pix_i,
  mbe_res_if.source                        res_o
);

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  mbe_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x       <= mbe_pkg::ORIGIN_RST;
      cfg_q.origin_y       <= mbe_pkg::ORIGIN_RST;
      cfg_q.pixel_step     <= mbe_pkg::STEP_RST;
      cfg_q.max_iterations <= mbe_pkg::MAX_ITER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mbe_pkg::REG_ORIGIN_X: cfg_q.origin_x       <= cfg_wdata_i;
        mbe_pkg::REG_ORIGIN_Y: cfg_q.origin_y       <= cfg_wdata_i;
        mbe_pkg::REG_STEP:     cfg_q.pixel_step     <= cfg_wdata_i[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_MAX_ITER: cfg_q.max_iterations <= cfg_wdata_i[mbe_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // front to queue
  logic                     push_valid;
  logic                     push_ready;
  mbe_pkg::point_t          push_data;
  // queue to engine
  logic                     pop_valid;
  logic                     pop_ready;
  mbe_pkg::point_t          pop_data;
  mbe_pkg::queue_status_t   q_status;
  mbe_pkg::core_status_t    core_status;

  // front: maps each pixel request to its point c
  mbe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pix_i        (pix_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // queue: lets front and engine stall apart
  mbe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data),
    .status_o     (q_status)
  );

  // engine: iteration loop plus output register
  mbe_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .res_o       (res_o),
    .status_o    (core_status)
  );

  // queue never holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.count <= mbe_pkg::QCNT_W'(mbe_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  // a full queue behind a loaded front stage must stall new requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid && q_status.full) |-> !pix_i.ready)
    else $error("request taken while front is blocked");

  // a result only appears after the engine worked on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(core_status.busy))
    else $error("result without engine activity");

endmodule
`default_nettype wire
